/* hdl/swlru_pkg.sv */
// Shared types, codes and defaults of the size-weighted LRU cache.
`timescale 1ns / 1ps
package swlru_pkg;

  localparam int DEF_ENTRIES     = 16;
  localparam int DEF_KEY_BITS    = 64;
  localparam int DEF_HANDLE_BITS = 32;

  localparam int SIZE_W = 33;
  localparam int CAP_W  = 32;
  localparam int OVH_W  = 13;

  localparam logic [CAP_W-1:0] CAP_RESET = 32'd1048576;
  localparam logic [OVH_W-1:0] OVH_RESET = 13'd24;

  localparam logic REG_CAPACITY = 1'b0;
  localparam logic REG_OVERHEAD = 1'b1;

  localparam logic [1:0] CMD_LOOKUP = 2'd0;
  localparam logic [1:0] CMD_STORE  = 2'd1;
  localparam logic [1:0] CMD_INVAL  = 2'd2;
  localparam logic [1:0] CMD_NONE   = 2'd3;

  localparam logic [2:0] ST_EVICTED  = 3'd0;
  localparam logic [2:0] ST_HIT      = 3'd1;
  localparam logic [2:0] ST_MISS     = 3'd2;
  localparam logic [2:0] ST_STORED   = 3'd3;
  localparam logic [2:0] ST_TOO_BIG  = 3'd4;
  localparam logic [2:0] ST_REMOVED  = 3'd5;
  localparam logic [2:0] ST_ABSENT   = 3'd6;

  localparam logic [2:0] OP_NONE    = 3'd0;
  localparam logic [2:0] OP_LATCH   = 3'd1;
  localparam logic [2:0] OP_SEL_HIT = 3'd2;
  localparam logic [2:0] OP_SEL_OLD = 3'd3;
  localparam logic [2:0] OP_TOUCH   = 3'd4;
  localparam logic [2:0] OP_REMOVE  = 3'd5;
  localparam logic [2:0] OP_REPLACE = 3'd6;
  localparam logic [2:0] OP_INSERT  = 3'd7;

  typedef struct packed {
    logic [2:0] op;
    logic       emit;
    logic [2:0] code;
  } dp_cmd_t;

  typedef struct packed {
    logic [1:0] cmd;
    logic       found;
    logic       too_big;
    logic       over;
    logic       any_valid;
    logic       full;
  } dp_stat_t;

endpackage

/* hdl/swlru_dp.sv */
// Datapath: slot table, recency ranks, byte accounting and result register.
`timescale 1ns / 1ps
module swlru_dp import swlru_pkg::*; #(
  parameter int ENTRIES     = DEF_ENTRIES,
  parameter int KEY_BITS    = DEF_KEY_BITS,
  parameter int HANDLE_BITS = DEF_HANDLE_BITS
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                wr_en,
  input  logic                wr_index,
  input  logic [CAP_W-1:0]    wr_data,
  input  logic [1:0]          cmd,
  input  logic [KEY_BITS-1:0] key,
  input  logic [31:0]         value_handle,
  input  logic [31:0]         object_size,
  input  dp_cmd_t             ctl,
  output dp_stat_t            stat,
  output logic [2:0]          status,
  output logic                done
);

  localparam int IDX_W = $clog2(ENTRIES);
  localparam int CNT_W = $clog2(ENTRIES + 1);

  logic [CAP_W-1:0]       capacity;
  logic [OVH_W-1:0]       overhead;
  logic [1:0]             cmd_q;
  logic [KEY_BITS-1:0]    key_q;
  logic [HANDLE_BITS-1:0] handle_q;
  logic [SIZE_W-1:0]      charge_q;

  logic [ENTRIES-1:0]     slot_valid;
  logic [IDX_W-1:0]       slot_age   [ENTRIES];
  logic [KEY_BITS-1:0]    slot_key   [ENTRIES];
  logic [HANDLE_BITS-1:0] slot_value [ENTRIES];
  logic [SIZE_W-1:0]      slot_size  [ENTRIES];
  logic [CNT_W-1:0]       nvalid;
  logic [SIZE_W-1:0]      total;
  logic [IDX_W-1:0]       sel;
  logic                   found;

  logic                   hit;
  logic [IDX_W-1:0]       hit_idx;
  logic [IDX_W-1:0]       old_idx;
  logic [IDX_W-1:0]       free_idx;
  logic [IDX_W-1:0]       old_rank;
  logic [IDX_W-1:0]       sel_age;
  logic [SIZE_W-1:0]      sel_size;
  logic [63:0]            vh_ext;

  assign vh_ext   = {32'd0, value_handle};
  assign old_rank = IDX_W'(nvalid - CNT_W'(1));
  assign sel_age  = slot_age[sel];
  assign sel_size = slot_size[sel];

  always_comb begin
    hit      = 1'b0;
    hit_idx  = '0;
    old_idx  = '0;
    free_idx = IDX_W'(ENTRIES - 1);
    for (int i = 0; i < ENTRIES; i++) begin
      if (slot_valid[i] && slot_key[i] == key_q && !hit) begin
        hit     = 1'b1;
        hit_idx = IDX_W'(i);
      end
      if (slot_valid[i] && slot_age[i] == old_rank) old_idx = IDX_W'(i);
    end
    // lowest free slot, last slot as fallback
    for (int i = ENTRIES - 2; i >= 0; i--) begin
      if (!slot_valid[i]) free_idx = IDX_W'(i);
    end
  end

  always_comb begin
    stat.cmd       = cmd_q;
    stat.found     = found;
    stat.too_big   = charge_q > {1'b0, capacity};
    stat.over      = ({1'b0, total} + {1'b0, charge_q}) > {2'b0, capacity};
    stat.any_valid = nvalid != '0;
    stat.full      = nvalid == CNT_W'(ENTRIES);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      capacity   <= CAP_RESET;
      overhead   <= OVH_RESET;
      slot_valid <= '0;
      nvalid     <= '0;
      total      <= '0;
      done       <= 1'b0;
      for (int i = 0; i < ENTRIES; i++) slot_age[i] <= '0;
    end else begin
      done <= ctl.emit;
      if (wr_en) begin
        if (wr_index == REG_CAPACITY) capacity <= wr_data;
        else overhead <= wr_data[OVH_W-1:0];
      end
      case (ctl.op)
        OP_TOUCH, OP_REPLACE: begin
          for (int i = 0; i < ENTRIES; i++)
            if (slot_valid[i] && slot_age[i] < sel_age) slot_age[i] <= slot_age[i] + 1'b1;
          slot_age[sel] <= '0;
          if (ctl.op == OP_REPLACE) total <= total - sel_size + charge_q;
        end
        OP_REMOVE: begin
          for (int i = 0; i < ENTRIES; i++)
            if (slot_valid[i] && slot_age[i] > sel_age) slot_age[i] <= slot_age[i] - 1'b1;
          slot_age[sel]   <= '0;
          slot_valid[sel] <= 1'b0;
          nvalid          <= nvalid - 1'b1;
          total           <= total - sel_size;
        end
        OP_INSERT: begin
          for (int i = 0; i < ENTRIES; i++)
            if (slot_valid[i]) slot_age[i] <= slot_age[i] + 1'b1;
          slot_age[free_idx]   <= '0;
          slot_valid[free_idx] <= 1'b1;
          nvalid               <= nvalid + 1'b1;
          total                <= total + charge_q;
        end
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    status <= ctl.code;
    case (ctl.op)
      OP_LATCH: begin
        cmd_q    <= cmd;
        key_q    <= key;
        handle_q <= vh_ext[HANDLE_BITS-1:0];
        charge_q <= {1'b0, object_size} + SIZE_W'(overhead);
      end
      OP_SEL_HIT: begin
        sel   <= hit_idx;
        found <= hit;
      end
      OP_SEL_OLD: sel <= old_idx;
      OP_REPLACE: begin
        slot_value[sel] <= handle_q;
        slot_size[sel]  <= charge_q;
      end
      OP_INSERT: begin
        slot_key[free_idx]   <= key_q;
        slot_value[free_idx] <= handle_q;
        slot_size[free_idx]  <= charge_q;
      end
      default: ;
    endcase
  end

endmodule

/* hdl/swlru_ctrl.sv */
// Controller: command sequencing, eviction walk and result codes.
`timescale 1ns / 1ps
module swlru_ctrl import swlru_pkg::*; (
  input  logic       clk,
  input  logic       rst,
  input  logic       start,
  input  logic [1:0] cmd,
  input  dp_stat_t   stat,
  output logic       busy,
  output dp_cmd_t    ctl
);

  localparam logic [3:0] S_IDLE = 4'd0;
  localparam logic [3:0] S_FIND = 4'd1;
  localparam logic [3:0] S_LK   = 4'd2;
  localparam logic [3:0] S_INV  = 4'd3;
  localparam logic [3:0] S_CHK  = 4'd4;
  localparam logic [3:0] S_EV   = 4'd5;
  localparam logic [3:0] S_EVR  = 4'd6;
  localparam logic [3:0] S_FULL = 4'd7;
  localparam logic [3:0] S_FR   = 4'd8;
  localparam logic [3:0] S_WR   = 4'd9;

  logic [3:0] state, state_next;

  assign busy = state != S_IDLE;

  always_comb begin
    state_next = state;
    ctl        = '{op: OP_NONE, emit: 1'b0, code: ST_EVICTED};
    unique case (state)
      S_IDLE: begin
        if (start && cmd != CMD_NONE) begin
          ctl.op     = OP_LATCH;
          state_next = S_FIND;
        end
      end
      S_FIND: begin
        ctl.op = OP_SEL_HIT;
        case (stat.cmd)
          CMD_LOOKUP: state_next = S_LK;
          CMD_STORE:  state_next = S_CHK;
          default:    state_next = S_INV;
        endcase
      end
      S_LK: begin
        ctl.emit = 1'b1;
        if (stat.found) begin
          ctl.op   = OP_TOUCH;
          ctl.code = ST_HIT;
        end else begin
          ctl.code = ST_MISS;
        end
        state_next = S_IDLE;
      end
      S_INV: begin
        ctl.emit = 1'b1;
        if (stat.found) begin
          ctl.op   = OP_REMOVE;
          ctl.code = ST_REMOVED;
        end else begin
          ctl.code = ST_ABSENT;
        end
        state_next = S_IDLE;
      end
      S_CHK: begin
        if (stat.too_big) begin
          ctl.emit   = 1'b1;
          ctl.code   = ST_TOO_BIG;
          state_next = S_IDLE;
        end else begin
          state_next = S_EV;
        end
      end
      S_EV: begin
        if (stat.any_valid && stat.over) begin
          ctl.op     = OP_SEL_OLD;
          state_next = S_EVR;
        end else begin
          // key may have gone with the evictions: match again
          ctl.op     = OP_SEL_HIT;
          state_next = S_FULL;
        end
      end
      S_EVR: begin
        ctl.op     = OP_REMOVE;
        ctl.emit   = 1'b1;
        ctl.code   = ST_EVICTED;
        state_next = S_EV;
      end
      S_FULL: begin
        if (!stat.found && stat.full) begin
          ctl.op     = OP_SEL_OLD;
          state_next = S_FR;
        end else begin
          state_next = S_WR;
        end
      end
      S_FR: begin
        ctl.op     = OP_REMOVE;
        ctl.emit   = 1'b1;
        ctl.code   = ST_EVICTED;
        state_next = S_WR;
      end
      S_WR: begin
        ctl.op     = stat.found ? OP_REPLACE : OP_INSERT;
        ctl.emit   = 1'b1;
        ctl.code   = ST_STORED;
        state_next = S_IDLE;
      end
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) state <= S_IDLE;
    else state <= state_next;
  end

endmodule

/* hdl/size_weighted_lru_cache.sv */
// Top level: byte-budgeted LRU cache with lookup, store and invalidate commands.
// Lookup and invalidate: command latched, key matched, result beat registered; busy until then.
// Store: evicts oldest entries while over budget, one more if a miss finds the table full, then
// writes, each eviction giving its own beat; a too-large store answers after the size check.
// Results are single-cycle beats on done; the receiver cannot stall.
// Reset (rst, synchronous): table empty, charge total zero, registers to defaults.
`timescale 1ns / 1ps
module size_weighted_lru_cache import swlru_pkg::*; #(
  parameter int ENTRIES     = DEF_ENTRIES,
  parameter int KEY_BITS    = DEF_KEY_BITS,
  parameter int HANDLE_BITS = DEF_HANDLE_BITS
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                wr_en,
  input  logic                wr_index,
  input  logic [CAP_W-1:0]    wr_data,
  input  logic                start,
  output logic                busy,
  input  logic [1:0]          cmd,
  input  logic [KEY_BITS-1:0] key,
  input  logic [31:0]         value_handle,
  input  logic [31:0]         object_size,
  output logic                done,
  output logic [2:0]          status
);

  dp_cmd_t  ctl;
  dp_stat_t stat;

  swlru_ctrl u_ctrl (
    .clk  (clk),
    .rst  (rst),
    .start(start),
    .cmd  (cmd),
    .stat (stat),
    .busy (busy),
    .ctl  (ctl)
  );

  swlru_dp #(
    .ENTRIES    (ENTRIES),
    .KEY_BITS   (KEY_BITS),
    .HANDLE_BITS(HANDLE_BITS)
  ) u_dp (
    .clk         (clk),
    .rst         (rst),
    .wr_en       (wr_en),
    .wr_index    (wr_index),
    .wr_data     (wr_data),
    .cmd         (cmd),
    .key         (key),
    .value_handle(value_handle),
    .object_size (object_size),
    .ctl         (ctl),
    .stat        (stat),
    .status      (status),
    .done        (done)
  );

  a_done_from_work: assert property (@(posedge clk) disable iff (rst)
    done |-> $past(busy))
    else $error("result beat without a command in progress");

  a_nop_stays_idle: assert property (@(posedge clk) disable iff (rst)
    (start && !busy && cmd == CMD_NONE) |=> !busy)
    else $error("unused command started work");

  a_cmd_goes_busy: assert property (@(posedge clk) disable iff (rst)
    (start && !busy && cmd != CMD_NONE) |=> busy)
    else $error("accepted command did not start");

  a_emit_once_idle: assert property (@(posedge clk) disable iff (rst)
    (ctl.emit && !busy) |-> 1'b0)
    else $error("result emitted from idle");

endmodule

/* tb/sv/size_weighted_lru_cache_tb.sv */
// Testbench for the size-weighted LRU cache: predicts status beats and checks them.
`timescale 1ns / 1ps
module size_weighted_lru_cache_tb;
  import swlru_pkg::*;

  localparam int SLOTS = DEF_ENTRIES;
  localparam int TAIL_CYCLES = 45;  // room for the longest store

  class lru_shadow;
    logic [CAP_W-1:0]  capacity;
    logic [OVH_W-1:0]  overhead;
    logic              valid [SLOTS];
    logic [63:0]       tag [SLOTS];
    logic [SIZE_W-1:0] charged [SLOTS];
    int                age [SLOTS];
    logic [SIZE_W-1:0] total;
    logic [2:0]        pending_status [$];
    int                errors;

    function void clear();
      capacity = CAP_RESET;
      overhead = OVH_RESET;
      total = '0;
      errors = 0;
      pending_status.delete();
      for (int i = 0; i < SLOTS; i++) begin
        valid[i] = 1'b0;
        age[i] = 0;
        tag[i] = '0;
        charged[i] = '0;
      end
    endfunction

    function void set_reg(logic idx, logic [CAP_W-1:0] data);
      if (idx == REG_CAPACITY) capacity = data;
      else overhead = data[OVH_W-1:0];
    endfunction

    function int find_tag(logic [63:0] k);
      for (int i = 0; i < SLOTS; i++)
        if (valid[i] && tag[i] == k) return i;
      return -1;
    endfunction

    function int used_slots();
      int n;
      n = 0;
      for (int i = 0; i < SLOTS; i++) if (valid[i]) n++;
      return n;
    endfunction

    function void evict_oldest();
      int s;
      int a;
      s = -1;
      for (int i = 0; i < SLOTS; i++)
        if (valid[i] && (s < 0 || age[i] > age[s])) s = i;
      a = age[s];
      for (int i = 0; i < SLOTS; i++)
        if (valid[i] && age[i] > a) age[i]--;
      valid[s] = 1'b0;
      age[s] = 0;
      total = total - charged[s];
      pending_status.push_back(ST_EVICTED);
    endfunction

    function void drop_slot(int s);
      int a;
      a = age[s];
      for (int i = 0; i < SLOTS; i++)
        if (valid[i] && age[i] > a) age[i]--;
      valid[s] = 1'b0;
      age[s] = 0;
      total = total - charged[s];
    endfunction

    function void make_newest(int s);
      int a;
      a = age[s];
      for (int i = 0; i < SLOTS; i++)
        if (valid[i] && age[i] < a) age[i]++;
      age[s] = 0;
    endfunction

    // accepted command beat
    function void note_command(logic [1:0] c, logic [63:0] k, logic [31:0] sz);
      logic [SIZE_W-1:0] charge;
      int f;
      int s;
      case (c)
        CMD_LOOKUP: begin
          f = find_tag(k);
          if (f >= 0) begin
            make_newest(f);
            pending_status.push_back(ST_HIT);
          end else begin
            pending_status.push_back(ST_MISS);
          end
        end
        CMD_STORE: begin
          charge = {1'b0, sz} + overhead;
          if (charge > {1'b0, capacity}) begin
            pending_status.push_back(ST_TOO_BIG);
          end else begin
            while (used_slots() > 0 && ({1'b0, total} + charge) > {2'b0, capacity})
              evict_oldest();
            f = find_tag(k);
            if (f < 0 && used_slots() == SLOTS) evict_oldest();
            if (f >= 0) begin
              total = total - charged[f];
              charged[f] = charge;
              make_newest(f);
            end else begin
              s = 0;
              while (s < SLOTS - 1 && valid[s]) s++;
              tag[s] = k;
              charged[s] = charge;
              for (int i = 0; i < SLOTS; i++) if (valid[i]) age[i]++;
              valid[s] = 1'b1;
              age[s] = 0;
            end
            total = total + charge;
            pending_status.push_back(ST_STORED);
          end
        end
        CMD_INVAL: begin
          f = find_tag(k);
          if (f >= 0) begin
            drop_slot(f);
            pending_status.push_back(ST_REMOVED);
          end else begin
            pending_status.push_back(ST_ABSENT);
          end
        end
        default: ;
      endcase
    endfunction

    function void check_status(logic [2:0] st);
      logic [2:0] want;
      if (pending_status.size() == 0) begin
        $error("status: unexpected beat, actual %0d", st);
        errors++;
      end else begin
        want = pending_status.pop_front();
        if (st !== want) begin
          $error("status: expected %0d, actual %0d", want, st);
          errors++;
        end
      end
    endfunction
  endclass

  logic              clk = 1'b0;
  logic              rst = 1'b1;
  logic              wr_en = 1'b0;
  logic              wr_index = REG_CAPACITY;
  logic [CAP_W-1:0]  wr_data = '0;
  logic              start = 1'b0;
  logic              busy;
  logic [1:0]        cmd = CMD_LOOKUP;
  logic [63:0]       key = '0;
  logic [31:0]       value_handle = '0;
  logic [31:0]       object_size = '0;
  logic              done;
  logic [2:0]        status;

  lru_shadow shadow = new();
  logic [63:0] key_pool [20];

  size_weighted_lru_cache dut (
    .clk(clk), .rst(rst), .wr_en(wr_en), .wr_index(wr_index), .wr_data(wr_data),
    .start(start), .busy(busy), .cmd(cmd), .key(key), .value_handle(value_handle),
    .object_size(object_size), .done(done), .status(status)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  always @(posedge clk) begin
    if (!rst && done) shadow.check_status(status);
  end

  initial begin
    #20ms;
    $display("== FAIL ==");
    $finish;
  end

  task automatic send(logic [1:0] c, logic [63:0] k, logic [31:0] sz);
    start <= 1'b1;
    cmd <= c;
    key <= k;
    value_handle <= $urandom;
    object_size <= sz;
    do @(posedge clk); while (busy);
    shadow.note_command(c, k, sz);
  endtask

  task automatic gap(int pct);
    if ($urandom_range(99) < pct) begin
      start <= 1'b0;
      do @(posedge clk); while ($urandom_range(99) < pct);
    end
  endtask

  task automatic drain();
    start <= 1'b0;
    @(posedge clk);
    while (shadow.pending_status.size() != 0) @(posedge clk);
    repeat (TAIL_CYCLES) @(posedge clk);
  endtask

  task automatic write_reg(logic idx, logic [CAP_W-1:0] data);
    wr_en <= 1'b1;
    wr_index <= idx;
    wr_data <= data;
    @(posedge clk);
    shadow.set_reg(idx, data);
    wr_en <= 1'b0;
    @(posedge clk);
  endtask

  task automatic run_random(int n, int pct, logic [31:0] max_size);
    logic [1:0]  c;
    logic [63:0] k;
    logic [31:0] sz;
    int r;
    for (int i = 0; i < n; i++) begin
      r = $urandom_range(99);
      c = r < 30 ? CMD_LOOKUP : r < 75 ? CMD_STORE : r < 95 ? CMD_INVAL : CMD_NONE;
      k = $urandom_range(99) < 85 ? key_pool[$urandom_range(19)] : {$urandom, $urandom};
      if (max_size == 0 || $urandom_range(9) == 0) sz = $urandom;
      else sz = $urandom_range(max_size, 0);
      send(c, k, sz);
      gap(pct);
    end
  endtask

  initial begin
    shadow.clear();
    for (int i = 0; i < 20; i++) key_pool[i] = {$urandom, $urandom};
    repeat (12) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // directed: hit, miss, replace, too large, remove, absent, unused command
    send(CMD_STORE, key_pool[0], 32'd0);
    send(CMD_LOOKUP, key_pool[0], 32'd0);
    send(CMD_LOOKUP, 64'hFFFF_FFFF_FFFF_FFFF, 32'd0);
    send(CMD_STORE, key_pool[0], 32'd100);
    send(CMD_STORE, key_pool[1], 32'hFFFF_FFFF);
    send(CMD_INVAL, key_pool[0], 32'd0);
    send(CMD_INVAL, key_pool[0], 32'd0);
    send(CMD_NONE, key_pool[2], 32'd5);
    // full table forces an eviction on the 17th distinct key
    for (int i = 0; i < 17; i++) send(CMD_STORE, key_pool[i], 32'd10);
    // budget evictions
    send(CMD_STORE, key_pool[3], 32'd600000);
    send(CMD_STORE, key_pool[18], 32'd600000);
    drain();

    run_random(45, 17, 32'd300000);
    drain();

    write_reg(REG_CAPACITY, 32'hFFFF_FFFF);
    write_reg(REG_OVERHEAD, 32'd0);
    send(CMD_STORE, key_pool[5], 32'd0);
    send(CMD_STORE, key_pool[6], 32'hFFFF_FFFF);
    run_random(70, 81, 32'd0);
    drain();

    // capacity lowered under the current charge total
    write_reg(REG_CAPACITY, 32'd5000);
    write_reg(REG_OVERHEAD, 32'd4096);
    run_random(70, 0, 32'd1000);
    drain();

    write_reg(REG_CAPACITY, 32'd1);
    write_reg(REG_OVERHEAD, 32'd1);
    run_random(10, 17, 32'd1);
    drain();
    write_reg(REG_CAPACITY, 32'd0);
    write_reg(REG_OVERHEAD, 32'd0);
    run_random(8, 0, 32'd1);
    drain();

    if (shadow.errors == 0 && shadow.pending_status.size() == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end
endmodule
